// ----- hdl/lvrpf_pkg.sv -----
`timescale 1ns / 1ps

package lvrpf_pkg;

  // label field and class set: every 2-bit label is a class of its own
  localparam int LABEL_W     = 2;
  localparam int NUM_CLASSES = 4;

  // result field width
  localparam int PEAK_W = 20;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_QRS_CLASS   = 1'b0;
  localparam logic [LABEL_W-1:0]   QRS_CLASS_RESET = 2'd1;

  // queue between vote and run tracking
  localparam int QUEUE_DEPTH = 2;

  // what the run tracker needs to know about one batch of voted samples
  typedef struct packed {
    logic q;      // voted label is the qrs class
    logic multi;  // batch holds two or more samples
    logic last;   // batch closes the segment
  } desc_ctl_t;

endpackage

// ----- hdl/lvrpf_front.sv -----
`timescale 1ns / 1ps

module lvrpf_front #(
  parameter int VOTE_WINDOW = 9,
  parameter int CNT_W       = 20,
  parameter int MAX_SEGMENT = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lvrpf_pkg::LABEL_W-1:0] in_label,
  input  logic                        in_last_sample,
  input  logic [lvrpf_pkg::LABEL_W-1:0] qrs_class,
  input  logic                        queue_full,
  output logic                        desc_push,
  output lvrpf_pkg::desc_ctl_t        desc_ctl,
  output logic [CNT_W-1:0]            desc_first,
  output logic [CNT_W-1:0]            desc_t
);

  localparam int HALF = VOTE_WINDOW / 2;
  localparam int LAG  = VOTE_WINDOW - 1 - HALF;
  localparam int VC_W = $clog2(VOTE_WINDOW + 1);

  logic [lvrpf_pkg::LABEL_W-1:0] win_r [VOTE_WINDOW];
  logic [VC_W-1:0]               cnt_r   [lvrpf_pkg::NUM_CLASSES];
  logic [VC_W-1:0]               cnt_nxt [lvrpf_pkg::NUM_CLASSES];
  logic [CNT_W-1:0]              t_r;
  logic [CNT_W-1:0]              t_nxt;
  logic                          accept;
  logic                          drop;
  logic                          full_win;
  logic [lvrpf_pkg::LABEL_W-1:0] old_label;
  logic [lvrpf_pkg::LABEL_W-1:0] best;
  logic [VC_W-1:0]               best_cnt;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    old_label = win_r[VOTE_WINDOW-1];
    drop      = 32'(t_r) >= 32'(VOTE_WINDOW);
    full_win  = 32'(t_r) == 32'(VOTE_WINDOW - 1);

    // running class counts over the window
    for (int c = 0; c < lvrpf_pkg::NUM_CLASSES; c++) begin
      cnt_nxt[c] = cnt_r[c] + VC_W'(in_label == lvrpf_pkg::LABEL_W'(c))
                 - VC_W'(drop && (old_label == lvrpf_pkg::LABEL_W'(c)));
    end

    // majority, ties to the lowest class
    best     = '0;
    best_cnt = cnt_nxt[0];
    for (int c = 1; c < lvrpf_pkg::NUM_CLASSES; c++) begin
      if (cnt_nxt[c] > best_cnt) begin
        best     = lvrpf_pkg::LABEL_W'(c);
        best_cnt = cnt_nxt[c];
      end
    end

    desc_push      = accept && (in_last_sample || drop || full_win);
    desc_ctl.q     = (best == qrs_class);
    desc_ctl.multi = in_last_sample ? (t_r != '0) : full_win;
    desc_ctl.last  = in_last_sample;
    desc_first     = drop ? (t_r - CNT_W'(LAG)) : '0;
    desc_t         = t_r;

    // saturating sample index
    if (t_r == CNT_W'(MAX_SEGMENT - 1)) begin
      t_nxt = t_r;
    end else begin
      t_nxt = t_r + CNT_W'(1);
    end
  end

  // label shift line, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= in_label;
      for (int k = 1; k < VOTE_WINDOW; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
      for (int c = 0; c < lvrpf_pkg::NUM_CLASSES; c++) begin
        cnt_r[c] <= '0;
      end
    end else if (accept) begin
      if (in_last_sample) begin
        t_r <= '0;
        for (int c = 0; c < lvrpf_pkg::NUM_CLASSES; c++) begin
          cnt_r[c] <= '0;
        end
      end else begin
        t_r <= t_nxt;
        for (int c = 0; c < lvrpf_pkg::NUM_CLASSES; c++) begin
          cnt_r[c] <= cnt_nxt[c];
        end
      end
    end
  end

endmodule

// ----- hdl/lvrpf_queue.sv -----
`timescale 1ns / 1ps

module lvrpf_queue #(
  parameter int WIDTH = 43
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(lvrpf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lvrpf_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [lvrpf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(lvrpf_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(lvrpf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(lvrpf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/lvrpf_back.sv -----
`timescale 1ns / 1ps

module lvrpf_back #(
  parameter int CNT_W = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           queue_empty,
  output logic                           queue_pop,
  input  lvrpf_pkg::desc_ctl_t           desc_ctl,
  input  logic [CNT_W-1:0]               desc_first,
  input  logic [CNT_W-1:0]               desc_t,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lvrpf_pkg::PEAK_W-1:0]   out_peak_index,
  output logic                           out_last_of_run
);

  localparam int EXT_W = (CNT_W > lvrpf_pkg::PEAK_W) ? CNT_W : lvrpf_pkg::PEAK_W;

  logic                          open_r;
  logic                          open_nxt;
  logic                          mark_r;
  logic                          mark_nxt;
  logic [CNT_W-1:0]              start_r;
  logic [CNT_W-1:0]              start_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [lvrpf_pkg::PEAK_W-1:0]  peak_r;
  logic                          take;
  logic                          emit;
  logic [CNT_W-1:0]              run_first;
  logic [CNT_W-1:0]              run_end;
  logic [CNT_W:0]                run_sum;
  logic [CNT_W-1:0]              mid;
  logic [EXT_W-1:0]              mid_ext;

  assign take      = !queue_empty && (!out_valid_r || !out_stall);
  assign queue_pop = take;

  always_comb begin
    open_nxt  = open_r;
    mark_nxt  = mark_r;
    start_nxt = start_r;
    emit      = 1'b0;
    run_first = start_r;
    run_end   = desc_t;

    if (desc_ctl.q) begin
      // qrs batch: opens a run or extends the open one
      if (!open_r) begin
        start_nxt = desc_first;
      end
      run_first = open_r ? start_r : desc_first;
      mark_nxt  = open_r || desc_ctl.multi;
      open_nxt  = 1'b1;
      emit      = desc_ctl.last && mark_nxt;
      run_end   = desc_t;
    end else begin
      // non-qrs batch closes a run that ended one sample earlier
      emit      = open_r && mark_r;
      run_first = start_r;
      run_end   = (desc_first != '0) ? (desc_first - CNT_W'(1)) : '0;
      mark_nxt  = 1'b0;
      open_nxt  = 1'b0;
    end

    if (desc_ctl.last) begin
      open_nxt = 1'b0;
      mark_nxt = 1'b0;
    end

    // floor of the midpoint equals start plus half the span
    run_sum = {1'b0, run_first} + {1'b0, run_end};
    mid     = (run_end > run_first) ? run_sum[CNT_W:1] : run_first;
    mid_ext = EXT_W'(mid);

    if (take) begin
      out_valid_nxt = emit;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      peak_r <= mid_ext[lvrpf_pkg::PEAK_W-1:0];
    end
    if (take) begin
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      mark_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        open_r <= open_nxt;
        mark_r <= mark_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_peak_index  = peak_r;
  // an item never causes more than one peak, so every word closes its item
  assign out_last_of_run = 1'b1;

endmodule

// ----- hdl/label_vote_r_peak_finder_top.sv -----
`timescale 1ns / 1ps
// a peak word is offered after the item that completes it is taken: the item's batch
// enters the queue, then the run tracker loads the output register
// throughput: one label word per cycle, sustained while the output side keeps up
// a voted sample trails its input by VOTE_WINDOW-1-VOTE_WINDOW/2 words; the rest flush on last
// reset: synchronous, active low; segment state and queue clear at once, qrs_class goes to 1

module label_vote_r_peak_finder_top #(
  parameter int VOTE_WINDOW = 9,
  parameter int MAX_SEGMENT = 1048576
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // label words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lvrpf_pkg::LABEL_W-1:0]       in_label,
  input  logic                                in_last_sample,
  // peak words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lvrpf_pkg::PEAK_W-1:0]        out_peak_index,
  output logic                                out_last_of_run,
  // register port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [lvrpf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [lvrpf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lvrpf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  // width of the saturating sample index
  localparam int CNT_W  = $clog2(MAX_SEGMENT);
  localparam int CTL_W  = $bits(lvrpf_pkg::desc_ctl_t);
  localparam int DESC_W = CTL_W + 2 * CNT_W;

  logic [lvrpf_pkg::LABEL_W-1:0]   qrs_class_r;
  logic [lvrpf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            cfg_write;

  logic                            desc_push;
  lvrpf_pkg::desc_ctl_t            front_ctl;
  logic [CNT_W-1:0]                front_first;
  logic [CNT_W-1:0]                front_t;
  logic [DESC_W-1:0]               push_data;
  logic [DESC_W-1:0]               head_data;
  logic                            queue_full;
  logic                            queue_empty;
  logic                            queue_pop;
  lvrpf_pkg::desc_ctl_t            head_ctl;
  logic [CNT_W-1:0]                head_first;
  logic [CNT_W-1:0]                head_t;

  // register port: no wait states, one word-aligned register
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[lvrpf_pkg::CFG_ADDR_W-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qrs_class_r <= lvrpf_pkg::QRS_CLASS_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        lvrpf_pkg::REG_QRS_CLASS: qrs_class_r <= cfg_pwdata[lvrpf_pkg::LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lvrpf_pkg::REG_QRS_CLASS: cfg_prdata = lvrpf_pkg::CFG_DATA_W'(qrs_class_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // front: window, class counts and vote; at most one batch descriptor per accepted label word
  lvrpf_front #(
    .VOTE_WINDOW (VOTE_WINDOW),
    .CNT_W       (CNT_W),
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_label       (in_label),
    .in_last_sample (in_last_sample),
    .qrs_class      (qrs_class_r),
    .queue_full     (queue_full),
    .desc_push      (desc_push),
    .desc_ctl       (front_ctl),
    .desc_first     (front_first),
    .desc_t         (front_t)
  );

  // short queue decouples the vote from the run tracker and output stalls
  assign push_data = {front_ctl, front_first, front_t};

  lvrpf_queue #(
    .WIDTH (DESC_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_data (push_data),
    .pop       (queue_pop),
    .head_data (head_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  assign head_ctl   = head_data[DESC_W-1 -: CTL_W];
  assign head_first = head_data[2*CNT_W-1 -: CNT_W];
  assign head_t     = head_data[CNT_W-1:0];

  // back: qrs run tracking and midpoint, output register towards the sink
  lvrpf_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .queue_empty     (queue_empty),
    .queue_pop       (queue_pop),
    .desc_ctl        (head_ctl),
    .desc_first      (head_first),
    .desc_t          (head_t),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_index  (out_peak_index),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // block geometry as instantiated below
  localparam int VOTE_W    = 9;
  localparam int HALF_W    = VOTE_W / 2;
  localparam int VOTE_LAG  = VOTE_W - 1 - HALF_W;
  localparam int MAX_SEG   = 1048576;
  localparam int CLASS_MAX = lvrpf_pkg::NUM_CLASSES - 1;
  // margin after the owed peak words have left; it also covers a
  // label word that finishes no peak at all
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_LEN      = 160;

  localparam logic [lvrpf_pkg::CFG_ADDR_W-1:0] ADDR_QRS_CLASS =
    lvrpf_pkg::CFG_ADDR_W'(4 * lvrpf_pkg::REG_QRS_CLASS);

  typedef struct packed {
    logic [lvrpf_pkg::PEAK_W-1:0] peak_index;
    logic                         last_of_run;
  } peak_word_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [lvrpf_pkg::LABEL_W-1:0]       in_label;
  logic                                in_last_sample;
  logic                                out_valid;
  logic                                out_stall;
  logic [lvrpf_pkg::PEAK_W-1:0]        out_peak_index;
  logic                                out_last_of_run;
  logic                                cfg_psel;
  logic                                cfg_penable;
  logic                                cfg_pwrite;
  logic [lvrpf_pkg::CFG_ADDR_W-1:0]    cfg_paddr;
  logic [lvrpf_pkg::CFG_DATA_W-1:0]    cfg_pwdata;
  logic [lvrpf_pkg::CFG_DATA_W-1:0]    cfg_prdata;
  logic                                cfg_pready;

  label_vote_r_peak_finder_top #(
    .VOTE_WINDOW(VOTE_W),
    .MAX_SEGMENT(MAX_SEG)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_label       (in_label),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_peak_index (out_peak_index),
    .out_last_of_run(out_last_of_run),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always #2 clk = ~clk;

  // software copy of the segment state and the qrs class register
  logic [lvrpf_pkg::LABEL_W-1:0] win_labels [VOTE_W];
  int                            class_tally [lvrpf_pkg::NUM_CLASSES];
  int unsigned                   seg_pos;
  bit                            prev_qrs;
  bit                            run_marked;
  int unsigned                   run_first;
  logic [lvrpf_pkg::LABEL_W-1:0] qrs_sel;
  int                            words_out;

  // peak words still owed by the block, oldest first
  peak_word_t peaks_due[$];
  peak_word_t due_word;
  int         errors = 0;

  // idling odds in percent, per input word and per output check, changed from phase to phase
  int idle_pct  = 0;
  int stall_pct = 0;

  task automatic clear_segment_state();
    foreach (win_labels[k]) win_labels[k] = '0;
    foreach (class_tally[c]) class_tally[c] = 0;
    seg_pos    = 0;
    prev_qrs   = 1'b0;
    run_marked = 1'b0;
    run_first  = 0;
  endtask

  // midpoint of a closed run, rounded down; never more than two per label word
  task automatic add_peak(int unsigned first, int unsigned stop);
    peak_word_t w;
    int unsigned mid;
    mid = (stop > first) ? first + (stop - first) / 2 : first;
    if (words_out < 2) begin
      w.peak_index  = mid[lvrpf_pkg::PEAK_W-1:0];
      w.last_of_run = 1'b0;
      peaks_due     = {peaks_due, w};
      words_out++;
    end
  endtask

  // one accepted label word: slide the window, vote, release voted samples
  // to the run tracker and queue the peaks that close, at most two
  task automatic predict_peaks(logic [lvrpf_pkg::LABEL_W-1:0] lab, logic last);
    int unsigned t;
    int unsigned first;
    int unsigned stop;
    int          best;
    bit          q;
    peak_word_t  w;
    t         = seg_pos;
    words_out = 0;
    if (t >= VOTE_W)
      class_tally[win_labels[VOTE_W-1]] = class_tally[win_labels[VOTE_W-1]] - 1;
    for (int k = VOTE_W - 1; k > 0; k--) win_labels[k] = win_labels[k-1];
    win_labels[0]    = lab;
    class_tally[lab] = class_tally[lab] + 1;

    // strict compare keeps ties on the lowest class
    best = 0;
    for (int c = 1; c < lvrpf_pkg::NUM_CLASSES; c++)
      if (class_tally[c] > class_tally[best]) best = c;
    q = (best == int'(qrs_sel));

    // edge windows: the opening samples share the first full window and a
    // closing word flushes everything still held back
    first = (t >= VOTE_W) ? t - VOTE_LAG : 0;
    if (last || t >= VOTE_W - 1) begin
      stop = last ? t : t - VOTE_LAG;
      for (int unsigned s = first; s <= stop; s++) begin
        if (q) begin
          if (!prev_qrs) run_first = s;
          else run_marked = 1'b1;
        end else begin
          if (prev_qrs && run_marked) add_peak(run_first, (s > 0) ? s - 1 : 0);
          run_marked = 1'b0;
        end
        prev_qrs = q;
      end
    end

    if (last) begin
      if (prev_qrs && run_marked) add_peak(run_first, t);
      clear_segment_state();
    end else if (t + 1 < MAX_SEG) begin
      seg_pos = t + 1;
    end
    // otherwise the index sticks at its top value while the window slides on

    if (words_out > 0) begin
      w = peaks_due.pop_back();
      w.last_of_run = 1'b1;
      peaks_due = {peaks_due, w};
    end
  endtask

  // label sender: optional gap, then hold the word until it is taken
  task automatic send_word(logic [lvrpf_pkg::LABEL_W-1:0] lab, logic last);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_label       <= lab;
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_peaks(lab, last);
  endtask

  // quiet the input, let every owed peak word out, then let the pipe settle
  task automatic wait_peaks_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (peaks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [lvrpf_pkg::CFG_ADDR_W-1:0] addr,
                           logic [lvrpf_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_QRS_CLASS) qrs_sel = data[lvrpf_pkg::LABEL_W-1:0];
    @(posedge clk);
  endtask

  task automatic cfg_read(logic [lvrpf_pkg::CFG_ADDR_W-1:0] addr,
                          logic [lvrpf_pkg::CFG_DATA_W-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      $display("%0t: register read at %0d: expected %0h, got %0h", $time, addr, want,
               cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // peak word checker, field by field against the oldest owed word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (peaks_due.size() == 0) begin
        $display("%0t: peak word with none owed: expected nothing, got index %0d last %0b",
                 $time, out_peak_index, out_last_of_run);
        errors++;
      end else begin
        due_word = peaks_due.pop_front();
        if (out_peak_index !== due_word.peak_index) begin
          $display("%0t: peak_index: expected %0d, got %0d", $time, due_word.peak_index,
                   out_peak_index);
          errors++;
        end
        if (out_last_of_run !== due_word.last_of_run) begin
          $display("%0t: last_of_run: expected %0b, got %0b", $time, due_word.last_of_run,
                   out_last_of_run);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure in random bursts, at odds of stall_pct
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // reset value, then every class in and back out of the register
  task automatic test_registers();
    cfg_read(ADDR_QRS_CLASS,
             {{(lvrpf_pkg::CFG_DATA_W-lvrpf_pkg::LABEL_W){1'b0}}, lvrpf_pkg::QRS_CLASS_RESET});
    for (int v = 0; v < lvrpf_pkg::NUM_CLASSES; v++) begin
      cfg_write(ADDR_QRS_CLASS, v);
      cfg_read(ADDR_QRS_CLASS, v);
    end
    cfg_write(ADDR_QRS_CLASS,
              {{(lvrpf_pkg::CFG_DATA_W-lvrpf_pkg::LABEL_W){1'b0}}, lvrpf_pkg::QRS_CLASS_RESET});
  endtask

  // hand-picked segments with qrs class 1, each word as {last, label}:
  // one-sample segments of a plain label and of a lone qrs sample, a
  // two-sample qrs run, a short segment with a tie between classes 1 and 2
  // that must go to 1, then a segment just over one window long
  task automatic test_directed();
    logic [2:0] plan [25];
    plan[0] = 3'b1_11;
    plan[1] = 3'b1_01;
    plan[2] = 3'b0_01;
    plan[3] = 3'b1_01;
    for (int i = 0; i < 8; i++) plan[4+i] = {(i == 7), (i < 4) ? 2'd1 : 2'd2};
    for (int i = 0; i < 13; i++) plan[12+i] = {(i == 12), (i < 6) ? 2'd0 : 2'd1};
    idle_pct  = 0;
    stall_pct = 30;
    foreach (plan[i]) send_word(plan[i][1:0], plan[i][2]);
    wait_peaks_drained();
  endtask

  // random segments built from label blocks so voted qrs runs really form,
  // with some pure noise segments and plenty of short ones
  task automatic test_random();
    int                            sent;
    int                            len;
    int                            blk_left;
    bit                            noisy;
    logic [lvrpf_pkg::LABEL_W-1:0] blk_lab;
    logic [lvrpf_pkg::LABEL_W-1:0] lab;
    for (int p = 0; p <= lvrpf_pkg::NUM_CLASSES; p++) begin
      cfg_write(ADDR_QRS_CLASS,
                (p < lvrpf_pkg::NUM_CLASSES) ? p : $urandom_range(0, CLASS_MAX));
      idle_pct  = (p == 1) ? 0 : 15 * $urandom_range(1, 3);
      stall_pct = (p == 2) ? 0 : 15 * $urandom_range(1, 3);
      sent = 0;
      while (sent < 240) begin
        case ($urandom_range(0, 9))
          0, 1:    len = $urandom_range(1, VOTE_W - 1);
          2:       len = $urandom_range(80, 200);
          default: len = $urandom_range(VOTE_W, 80);
        endcase
        noisy    = ($urandom_range(0, 7) == 0);
        blk_left = 0;
        for (int i = 0; i < len; i++) begin
          if (blk_left == 0) begin
            blk_lab  = $urandom_range(0, 1) ? qrs_sel :
                       lvrpf_pkg::LABEL_W'($urandom_range(0, CLASS_MAX));
            blk_left = $urandom_range(1, 14);
          end
          if (noisy || $urandom_range(0, 7) == 0)
            lab = lvrpf_pkg::LABEL_W'($urandom_range(0, CLASS_MAX));
          else lab = blk_lab;
          send_word(lab, i == len - 1);
          blk_left--;
        end
        sent += len;
      end
      wait_peaks_drained();
    end
  endtask

  // one long segment with no idling on either side; qrs bursts of varied
  // length every 32 samples put peaks all along the segment
  task automatic test_long_segment();
    int                            burst;
    logic [lvrpf_pkg::LABEL_W-1:0] filler;
    logic [lvrpf_pkg::LABEL_W-1:0] lab;
    idle_pct  = 0;
    stall_pct = 0;
    cfg_write(ADDR_QRS_CLASS, 2);
    filler = qrs_sel + 2'd1;
    burst  = 0;
    for (int i = 0; i < LONG_LEN; i++) begin
      if (i % 32 == 0) burst = $urandom_range(2, 12);
      if (i % 32 >= 10 && i % 32 < 10 + burst) lab = qrs_sel;
      else if ($urandom_range(0, 15) == 0)
        lab = lvrpf_pkg::LABEL_W'($urandom_range(0, CLASS_MAX));
      else lab = filler;
      send_word(lab, i == LONG_LEN - 1);
    end
    wait_peaks_drained();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_label       <= '0;
    in_last_sample <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    clear_segment_state();
    qrs_sel = lvrpf_pkg::QRS_CLASS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_registers();
    test_directed();
    test_random();
    test_long_segment();

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- label_vote_r_peak_finder_top.f -----
hdl/lvrpf_pkg.sv
hdl/lvrpf_front.sv
hdl/lvrpf_queue.sv
hdl/lvrpf_back.sv
hdl/label_vote_r_peak_finder_top.sv
verif/tb.sv
